### src/bfha_pkg.sv
package bfha_pkg;

    localparam int HEAP_BYTES   = 4096;
    localparam int MAX_FREE     = 64;
    localparam int HEADER_BYTES = 24;

    localparam int ADDR_W = 12;
    localparam int LEN_W  = 13;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_ZERO  = 3'd1;
    localparam logic [2:0] ST_OOH   = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_NULL  = 3'd4;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] start;
    } tbl_entry_t;

endpackage

### src/bfha_ram.sv
module bfha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/best_fit_heap_allocator_unit.sv
// Best-fit heap allocator over a 4096-byte heap with a 24-byte header per block.
// A request is taken, then the valid free-table entries are scanned for the best
// fit or the insertion point, then the decision is made, and, when an entry is
// removed or inserted, the table entries that have to move are shifted before
// the result is given; zero-size allocations and null frees skip straight to
// the result. The single read port of the free table memory sets the pace: the
// scan and the shift read one entry a cycle. The free table (64 entries) and the
// per-header block lengths (4096 entries) sit in RAMs that need no clearing after
// reset. A finished result is held in the output register while the next request
// is taken.
module best_fit_heap_allocator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // req_size[12:0], addr[24:13], zero fill
    input  logic        s_tuser,   // func: 0 allocate, 1 free
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // addr_out[11:0], status[14:12], zero fill
);
    import bfha_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam logic [ADDR_W-1:0] HDR_A = ADDR_W'(HEADER_BYTES);
    localparam logic [LEN_W-1:0]  HDR_L = LEN_W'(HEADER_BYTES);

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              func_reg, func_next;
    logic [LEN_W-1:0]  size_reg, size_next;
    logic [ADDR_W-1:0] hdr_reg, hdr_next;
    logic [LEN_W-1:0]  blen_reg, blen_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  brk_reg, brk_next;

    logic              found_reg, found_next;
    logic              exact_reg, exact_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    tbl_entry_t        best_reg, best_next;

    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              has_next_reg, has_next_next;
    tbl_entry_t        prev_reg, prev_next;
    tbl_entry_t        nxt_reg, nxt_next;

    logic              sh_left_reg, sh_left_next;
    logic              sh_ins_reg, sh_ins_next;
    logic              sh_more_reg, sh_more_next;
    logic              sh_pend_reg, sh_pend_next;
    logic [CNT_W-1:0]  sh_rd_reg, sh_rd_next;
    logic [CNT_W-1:0]  sh_last_reg, sh_last_next;
    logic [IDX_W-1:0]  sh_wa_reg, sh_wa_next;

    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic [2:0]        m_status_reg, m_status_next;

    logic              tbl_we;
    logic [IDX_W-1:0]  tbl_waddr, tbl_raddr;
    tbl_entry_t        tbl_wdata, tbl_rdata;
    logic              bl_we;
    logic [ADDR_W-1:0] bl_waddr, bl_raddr;
    logic [LEN_W-1:0]  bl_wdata, bl_rdata;

    logic [ADDR_W-1:0] a_in, hdr_in;
    logic [LEN_W-1:0]  diff;
    logic [14:0]       carve_end;
    logic [13:0]       prev_end, merged_end;
    logic [LEN_W-1:0]  plen;
    logic              mp, mn;

    bfha_ram #(.WIDTH($bits(tbl_entry_t)), .DEPTH(MAX_FREE)) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    bfha_ram #(.WIDTH(LEN_W), .DEPTH(HEAP_BYTES)) u_len (
        .clk   (clk),
        .we    (bl_we),
        .waddr (bl_waddr),
        .wdata (bl_wdata),
        .raddr (bl_raddr),
        .rdata (bl_rdata)
    );

    assign a_in   = s_tdata[24:13];
    assign hdr_in = a_in - HDR_A;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_status_reg, m_addr_reg};

    // Merge checks against the neighbors found by the scan.
    assign diff       = best_reg.len - size_reg;
    assign carve_end  = {2'b00, brk_reg} + 15'(HEADER_BYTES) + {2'b00, size_reg};
    assign prev_end   = {2'b00, prev_reg.start} + 14'(HEADER_BYTES) + {1'b0, prev_reg.len};
    assign plen       = prev_reg.len + HDR_L + blen_reg;
    assign mp         = (pos_reg != '0) && (prev_end == {2'b00, hdr_reg});
    assign merged_end = mp ? ({2'b00, prev_reg.start} + 14'(HEADER_BYTES) + {1'b0, plen})
                           : ({2'b00, hdr_reg} + 14'(HEADER_BYTES) + {1'b0, blen_reg});
    assign mn         = has_next_reg && (merged_end == {2'b00, nxt_reg.start});

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        func_next       = func_reg;
        size_next       = size_reg;
        hdr_next        = hdr_reg;
        blen_next       = blen_reg;
        count_next      = count_reg;
        brk_next        = brk_reg;
        found_next      = found_reg;
        exact_next      = exact_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        pos_next        = pos_reg;
        has_next_next   = has_next_reg;
        prev_next       = prev_reg;
        nxt_next        = nxt_reg;
        sh_left_next    = sh_left_reg;
        sh_ins_next     = sh_ins_reg;
        sh_more_next    = sh_more_reg;
        sh_pend_next    = sh_pend_reg;
        sh_rd_next      = sh_rd_reg;
        sh_last_next    = sh_last_reg;
        sh_wa_next      = sh_wa_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_addr_next     = m_addr_reg;
        m_status_next   = m_status_reg;

        tbl_we    = 1'b0;
        tbl_waddr = '0;
        tbl_wdata = '0;
        tbl_raddr = idx_reg[IDX_W-1:0];
        bl_we     = 1'b0;
        bl_waddr  = best_reg.start;
        bl_wdata  = size_reg;
        bl_raddr  = (state_reg == S_IDLE) ? hdr_in : hdr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next       = s_tuser;
                    size_next       = s_tdata[12:0];
                    hdr_next        = hdr_in;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    exact_next      = 1'b0;
                    pos_next        = '0;
                    has_next_next   = 1'b0;
                    res_addr_next   = '0;
                    res_status_next = ST_OK;
                    if (s_tuser == FUNC_ALLOC && s_tdata[12:0] == '0)
                    begin
                        res_status_next = ST_ZERO;
                        state_next      = S_DONE;
                    end
                    else if (s_tuser == FUNC_FREE && a_in < HDR_A)
                    begin
                        res_status_next = ST_NULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // The RAM read is registered, so step idx evaluates entry
                // idx-1; step zero picks up the block length.
                if (idx_reg == '0)
                begin
                    blen_next = bl_rdata;
                end
                else if (func_reg == FUNC_ALLOC)
                begin
                    if (!exact_reg)
                    begin
                        if (tbl_rdata.len == size_reg)
                        begin
                            exact_next    = 1'b1;
                            found_next    = 1'b1;
                            best_idx_next = IDX_W'(idx_reg - 1'b1);
                            best_next     = tbl_rdata;
                        end
                        else if (tbl_rdata.len > size_reg &&
                                 (!found_reg || tbl_rdata.len < best_reg.len))
                        begin
                            found_next    = 1'b1;
                            best_idx_next = IDX_W'(idx_reg - 1'b1);
                            best_next     = tbl_rdata;
                        end
                    end
                end
                else if (!has_next_reg)
                begin
                    if (tbl_rdata.start <= hdr_reg)
                    begin
                        prev_next = tbl_rdata;
                        pos_next  = idx_reg;
                    end
                    else
                    begin
                        has_next_next = 1'b1;
                        nxt_next      = tbl_rdata;
                    end
                end
                if (idx_reg == count_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_DECIDE:
            begin
                state_next   = S_DONE;
                sh_pend_next = 1'b0;
                if (func_reg == FUNC_ALLOC)
                begin
                    if (found_reg)
                    begin
                        bl_we         = 1'b1;
                        bl_waddr      = best_reg.start;
                        res_addr_next = best_reg.start + HDR_A;
                        if (diff >= HDR_L)
                        begin
                            bl_wdata        = size_reg;
                            tbl_we          = 1'b1;
                            tbl_waddr       = best_idx_reg;
                            tbl_wdata.len   = diff - HDR_L;
                            tbl_wdata.start = best_reg.start + HDR_A + size_reg[ADDR_W-1:0];
                        end
                        else
                        begin
                            bl_wdata     = best_reg.len;
                            sh_left_next = 1'b1;
                            sh_ins_next  = 1'b0;
                            sh_rd_next   = {1'b0, best_idx_reg} + 1'b1;
                            sh_last_next = count_reg - 1'b1;
                            sh_more_next = ({1'b0, best_idx_reg} + 1'b1) < count_reg;
                            state_next   = S_SHIFT;
                        end
                    end
                    else if (carve_end > 15'(HEAP_BYTES))
                    begin
                        res_status_next = ST_OOH;
                    end
                    else
                    begin
                        brk_next      = carve_end[LEN_W-1:0];
                        bl_we         = !brk_reg[LEN_W-1];
                        bl_waddr      = brk_reg[ADDR_W-1:0];
                        bl_wdata      = size_reg;
                        res_addr_next = brk_reg[ADDR_W-1:0] + HDR_A;
                    end
                end
                else
                begin
                    if (mp && mn)
                    begin
                        tbl_we          = 1'b1;
                        tbl_waddr       = IDX_W'(pos_reg - 1'b1);
                        tbl_wdata.start = prev_reg.start;
                        tbl_wdata.len   = plen + HDR_L + nxt_reg.len;
                        sh_left_next    = 1'b1;
                        sh_ins_next     = 1'b0;
                        sh_rd_next      = pos_reg + 1'b1;
                        sh_last_next    = count_reg - 1'b1;
                        sh_more_next    = (pos_reg + 1'b1) < count_reg;
                        state_next      = S_SHIFT;
                    end
                    else if (mp)
                    begin
                        tbl_we          = 1'b1;
                        tbl_waddr       = IDX_W'(pos_reg - 1'b1);
                        tbl_wdata.start = prev_reg.start;
                        tbl_wdata.len   = plen;
                    end
                    else if (mn)
                    begin
                        tbl_we          = 1'b1;
                        tbl_waddr       = pos_reg[IDX_W-1:0];
                        tbl_wdata.start = hdr_reg;
                        tbl_wdata.len   = blen_reg + HDR_L + nxt_reg.len;
                    end
                    else if (count_reg >= CNT_W'(MAX_FREE))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        sh_left_next = 1'b0;
                        sh_ins_next  = 1'b1;
                        sh_rd_next   = count_reg - 1'b1;
                        sh_last_next = pos_reg;
                        sh_more_next = (count_reg != pos_reg);
                        state_next   = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // One entry is read per cycle and written in the following cycle,
                // one slot toward the shift direction.
                tbl_raddr = sh_rd_reg[IDX_W-1:0];
                if (sh_pend_reg)
                begin
                    tbl_we    = 1'b1;
                    tbl_waddr = sh_wa_reg;
                    tbl_wdata = tbl_rdata;
                end
                sh_pend_next = sh_more_reg;
                if (sh_more_reg)
                begin
                    sh_wa_next = sh_left_reg ? IDX_W'(sh_rd_reg - 1'b1)
                                             : IDX_W'(sh_rd_reg + 1'b1);
                    if (sh_rd_reg == sh_last_reg)
                    begin
                        sh_more_next = 1'b0;
                    end
                    else
                    begin
                        sh_rd_next = sh_left_reg ? sh_rd_reg + 1'b1 : sh_rd_reg - 1'b1;
                    end
                end
                if (!sh_more_reg && !sh_pend_reg)
                begin
                    if (sh_ins_reg)
                    begin
                        tbl_we          = 1'b1;
                        tbl_waddr       = pos_reg[IDX_W-1:0];
                        tbl_wdata.start = hdr_reg;
                        tbl_wdata.len   = blen_reg;
                        count_next      = count_reg + 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_addr_next   = res_addr_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            brk_reg     <= '0;
            m_valid_reg <= 1'b0;
            sh_more_reg <= 1'b0;
            sh_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            brk_reg     <= brk_next;
            m_valid_reg <= m_valid_next;
            sh_more_reg <= sh_more_next;
            sh_pend_reg <= sh_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        func_reg       <= func_next;
        size_reg       <= size_next;
        hdr_reg        <= hdr_next;
        blen_reg       <= blen_next;
        found_reg      <= found_next;
        exact_reg      <= exact_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        pos_reg        <= pos_next;
        has_next_reg   <= has_next_next;
        prev_reg       <= prev_next;
        nxt_reg        <= nxt_next;
        sh_left_reg    <= sh_left_next;
        sh_ins_reg     <= sh_ins_next;
        sh_rd_reg      <= sh_rd_next;
        sh_last_reg    <= sh_last_next;
        sh_wa_reg      <= sh_wa_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_addr_reg     <= m_addr_next;
        m_status_reg   <= m_status_next;
    end

endmodule
